>>> rtl/wrc_pkg.sv
// ----------------------------------------------------------------------------
// wrc_pkg
// Types, constants and helper functions shared by the work/rest countdown
// block.
// ----------------------------------------------------------------------------
package wrc_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned NOW_W      = 31;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned MIN_W      = 7;
  localparam int unsigned SEC_W      = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [SEC_W-1:0] SEC_PER_MIN  = SEC_W'(60);
  localparam logic [SEC_W-1:0] SEC_MAX      = SEC_W'(8191);
  localparam logic [MIN_W-1:0] MINUTES_LO   = MIN_W'(1);
  localparam logic [MIN_W-1:0] MINUTES_HI   = MIN_W'(99);
  localparam logic [MIN_W-1:0] WORK_MIN_RST = MIN_W'(25);
  localparam logic [MIN_W-1:0] REST_MIN_RST = MIN_W'(5);

  localparam logic [CMD_W-1:0] CMD_NONE = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_ACT  = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_ACT2 = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_INC  = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_DEC  = CMD_W'(4);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_MINUTES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MINUTES = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_RUN   = 3'd1,
    MODE_PAUSE = 3'd2,
    MODE_ALARM = 3'd3,
    MODE_EDIT  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [NOW_W-1:0]         now_seconds;
    logic signed [STEP_W-1:0] edit_step;
  } item_t;

  typedef struct packed {
    mode_e              mode;
    logic               phase;
    logic               edit_field;
    logic [SEC_W-1:0]   display_seconds;
    logic [MIN_W-1:0]   work_length;
    logic [MIN_W-1:0]   rest_length;
    logic               redraw;
    logic               alarm_on;
  } result_t;

  function automatic logic [SEC_W-1:0] mins_to_sec(input logic [MIN_W-1:0] m);
    return SEC_W'(m) * SEC_PER_MIN;
  endfunction

  function automatic logic [MIN_W-1:0] bound_min(input logic [MIN_W-1:0] v);
    logic [MIN_W-1:0] r;
    r = v;
    if (v < MINUTES_LO) begin
      r = MINUTES_LO;
    end else if (v > MINUTES_HI) begin
      r = MINUTES_HI;
    end
    return r;
  endfunction

endpackage

>>> rtl/wrc_if.sv
// ----------------------------------------------------------------------------
// wrc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface wrc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [wrc_pkg::CMD_W-1:0]            cmd;
  logic [wrc_pkg::NOW_W-1:0]            now_seconds;
  logic signed [wrc_pkg::STEP_W-1:0]    edit_step;

  modport source (output valid, output cmd, output now_seconds, output edit_step,
                  input ready);
  modport sink (input valid, input cmd, input now_seconds, input edit_step,
                output ready);
endinterface

interface wrc_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                mode;
  logic                      phase;
  logic                      edit_field;
  logic [wrc_pkg::SEC_W-1:0] display_seconds;
  logic [wrc_pkg::MIN_W-1:0] work_length;
  logic [wrc_pkg::MIN_W-1:0] rest_length;
  logic                      redraw;
  logic                      alarm_on;

  modport source (output valid, output mode, output phase, output edit_field,
                  output display_seconds, output work_length, output rest_length,
                  output redraw, output alarm_on, input ready);
  modport sink (input valid, input mode, input phase, input edit_field,
                input display_seconds, input work_length, input rest_length,
                input redraw, input alarm_on, output ready);
endinterface

>>> rtl/work_rest_countdown_fsm_top.sv
// throughput: one item per cycle unless the result side stalls; the state update
// for an item is one pass through wrc_core between the input register and the
// result register
// back-pressure on the result side stalls the input register, then in_i.ready
// reset: asynchronous, active low; idle, work phase, 25 work and 5 rest minutes,
// 1500 seconds shown, clamp bounds 1 and 99, both channels empty
// ----------------------------------------------------------------------------
// work_rest_countdown_fsm_top
// Five-mode work/rest countdown with alarm and minute editing; one result per
// input item.
// ----------------------------------------------------------------------------
module work_rest_countdown_fsm_top #(
  parameter int unsigned TIME_WIDTH = wrc_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  wrc_in_if.sink                          in_i,
  wrc_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [wrc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wrc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import wrc_pkg::*;

  logic             in_valid_q;
  item_t            item_q;
  logic             out_valid_q;
  result_t          res_q;
  result_t          res_d;
  logic [MIN_W-1:0] min_q;
  logic [MIN_W-1:0] max_q;
  logic             fire;

  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MINUTES_LO;
      max_q <= MINUTES_HI;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_MINUTES: min_q <= cfg_data_i;
        REG_MAX_MINUTES: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.cmd         <= in_i.cmd;
      item_q.now_seconds <= in_i.now_seconds;
      item_q.edit_step   <= in_i.edit_step;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  wrc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .item_i (item_q),
    .min_i  (min_q),
    .max_i  (max_q),
    .res_o  (res_d)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.mode            = res_q.mode;
  assign out_o.phase           = res_q.phase;
  assign out_o.edit_field      = res_q.edit_field;
  assign out_o.display_seconds = res_q.display_seconds;
  assign out_o.work_length     = res_q.work_length;
  assign out_o.rest_length     = res_q.rest_length;
  assign out_o.redraw          = res_q.redraw;
  assign out_o.alarm_on        = res_q.alarm_on;

endmodule

>>> rtl/wrc_core.sv
// ----------------------------------------------------------------------------
// wrc_core
// Countdown state registers and the next-state logic for one item; gives the
// result of the item being stepped.
// ----------------------------------------------------------------------------
module wrc_core #(
  parameter int unsigned TIME_WIDTH = wrc_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  wrc_pkg::item_t                item_i,
  input  logic [wrc_pkg::MIN_W-1:0]     min_i,
  input  logic [wrc_pkg::MIN_W-1:0]     max_i,
  output wrc_pkg::result_t              res_o
);
  import wrc_pkg::*;

  localparam int unsigned ADJ_W = MIN_W + 3;

  mode_e                  mode_q, mode_d;
  logic                   phase_q, phase_d;
  logic                   field_q, field_d;
  logic [TIME_WIDTH-1:0]  deadline_q, deadline_d;
  logic [SEC_W-1:0]       saved_q, saved_d;
  logic [SEC_W-1:0]       shown_q, shown_d;
  logic [MIN_W-1:0]       work_q, work_d;
  logic [MIN_W-1:0]       rest_q, rest_d;
  logic                   alarm_q, alarm_d;

  logic [TIME_WIDTH-1:0]  now_t;
  logic [TIME_WIDTH-1:0]  diff_old, diff_new;
  logic                   exp_old;
  logic [SEC_W-1:0]       left_old, left_new;
  logic [MIN_W-1:0]       phase_mins, edit_val, lo, hi, adj;
  logic signed [ADJ_W-1:0] sum;
  logic                   redraw;

  function automatic logic is_expired(input logic [TIME_WIDTH-1:0] d);
    return (d == '0) || d[TIME_WIDTH-1];
  endfunction

  function automatic logic [SEC_W-1:0] sat_left(input logic [TIME_WIDTH-1:0] d);
    logic [SEC_W-1:0] r;
    r = d[SEC_W-1:0];
    if (is_expired(d)) begin
      r = '0;
    end else if (|d[TIME_WIDTH-2:SEC_W]) begin
      r = SEC_MAX;
    end
    return r;
  endfunction

  always_comb begin
    now_t      = TIME_WIDTH'(item_i.now_seconds);
    diff_old   = deadline_q - now_t;
    exp_old    = is_expired(diff_old);
    left_old   = sat_left(diff_old);
    phase_mins = phase_q ? rest_q : work_q;

    edit_val = field_q ? rest_q : work_q;
    lo       = bound_min(min_i);
    hi       = bound_min(max_i);
    sum      = signed'(ADJ_W'(edit_val)) + ADJ_W'(item_i.edit_step);
    if (sum < signed'(ADJ_W'(lo))) begin
      adj = lo;
    end else if (sum > signed'(ADJ_W'(hi))) begin
      adj = hi;
    end else begin
      adj = sum[MIN_W-1:0];
    end

    mode_d     = mode_q;
    phase_d    = phase_q;
    field_d    = field_q;
    deadline_d = deadline_q;
    saved_d    = saved_q;
    work_d     = work_q;
    rest_d     = rest_q;
    alarm_d    = alarm_q;
    redraw     = 1'b0;

    case (mode_q)
      MODE_IDLE: begin
        if (item_i.cmd == CMD_ACT) begin
          mode_d     = MODE_RUN;
          deadline_d = now_t + TIME_WIDTH'(mins_to_sec(phase_mins));
          redraw     = 1'b1;
        end else if (item_i.cmd == CMD_ACT2) begin
          mode_d  = MODE_EDIT;
          field_d = 1'b0;
          redraw  = 1'b1;
        end
      end
      MODE_RUN: begin
        if (item_i.cmd == CMD_ACT) begin
          mode_d  = MODE_PAUSE;
          saved_d = left_old;
          redraw  = 1'b1;
        end
        if (exp_old) begin
          mode_d  = MODE_ALARM;
          alarm_d = 1'b1;
          redraw  = 1'b1;
        end
        if (item_i.cmd == CMD_ACT2) begin
          mode_d  = MODE_EDIT;
          field_d = 1'b0;
          redraw  = 1'b1;
        end
      end
      MODE_PAUSE: begin
        if (item_i.cmd == CMD_ACT) begin
          mode_d     = MODE_RUN;
          deadline_d = now_t + TIME_WIDTH'(saved_q);
          redraw     = 1'b1;
        end
        if (item_i.cmd == CMD_ACT2) begin
          mode_d  = MODE_EDIT;
          field_d = 1'b0;
          redraw  = 1'b1;
        end
      end
      MODE_ALARM: begin
        if (item_i.cmd == CMD_ACT) begin
          alarm_d = 1'b0;
          if (!phase_q) begin
            phase_d    = 1'b1;
            saved_d    = mins_to_sec(rest_q);
            mode_d     = MODE_RUN;
            deadline_d = now_t + TIME_WIDTH'(mins_to_sec(rest_q));
          end else begin
            phase_d = 1'b0;
            saved_d = mins_to_sec(work_q);
            mode_d  = MODE_IDLE;
          end
          redraw = 1'b1;
        end
      end
      default: begin
        if (item_i.cmd == CMD_ACT) begin
          field_d = ~field_q;
          redraw  = 1'b1;
        end else if (item_i.cmd == CMD_ACT2) begin
          mode_d  = MODE_IDLE;
          saved_d = mins_to_sec(phase_mins);
          redraw  = 1'b1;
        end else if (item_i.cmd == CMD_INC || item_i.cmd == CMD_DEC) begin
          if (!field_q) begin
            work_d = adj;
          end else begin
            rest_d = adj;
          end
          redraw = 1'b1;
        end
      end
    endcase

    diff_new = deadline_d - now_t;
    left_new = sat_left(diff_new);
    shown_d  = (mode_d == MODE_RUN) ? left_new : saved_d;
    if (shown_d != shown_q) begin
      redraw = 1'b1;
    end

    res_o.mode            = mode_d;
    res_o.phase           = phase_d;
    res_o.edit_field      = field_d;
    res_o.display_seconds = shown_d;
    res_o.work_length     = work_d;
    res_o.rest_length     = rest_d;
    res_o.redraw          = redraw;
    res_o.alarm_on        = alarm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      phase_q    <= 1'b0;
      field_q    <= 1'b0;
      deadline_q <= '0;
      saved_q    <= mins_to_sec(WORK_MIN_RST);
      shown_q    <= mins_to_sec(WORK_MIN_RST);
      work_q     <= WORK_MIN_RST;
      rest_q     <= REST_MIN_RST;
      alarm_q    <= 1'b0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      field_q    <= field_d;
      deadline_q <= deadline_d;
      saved_q    <= saved_d;
      shown_q    <= shown_d;
      work_q     <= work_d;
      rest_q     <= rest_d;
      alarm_q    <= alarm_d;
    end
  end

endmodule

>>> rtl/wrc_checker.sv
// ----------------------------------------------------------------------------
// wrc_checker
// Port-level checks on the countdown block, bound to the top level.
// ----------------------------------------------------------------------------
module wrc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [2:0]                out_mode_i,
  input logic                      out_alarm_on_i,
  input logic [wrc_pkg::MIN_W-1:0] out_work_length_i,
  input logic [wrc_pkg::MIN_W-1:0] out_rest_length_i
);
  import wrc_pkg::*;

  // result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // input only stalls behind a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // alarm mode always sounds
  a_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_mode_i == MODE_ALARM |-> out_alarm_on_i)
    else $error("alarm mode without alarm");

  // minute lengths never leave MINUTES_LO to MINUTES_HI
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_work_length_i >= MINUTES_LO && out_work_length_i <= MINUTES_HI
                    && out_rest_length_i >= MINUTES_LO && out_rest_length_i <= MINUTES_HI)
    else $error("phase length out of range");

endmodule

bind work_rest_countdown_fsm_top wrc_checker u_wrc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_mode_i        (out_o.mode),
  .out_alarm_on_i    (out_o.alarm_on),
  .out_work_length_i (out_o.work_length),
  .out_rest_length_i (out_o.rest_length)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the work/rest countdown block against a cycle-free model of its
// modes, deadline arithmetic and minute clamping. Directed items cover edges,
// clamp settings and random button/time sequences, run under three idle
// patterns, follow.
// ----------------------------------------------------------------------------
module tb;
  import wrc_pkg::*;

  localparam int unsigned TW = TIME_WIDTH_DEF;

  localparam logic [CMD_W-1:0] CMD_RSVD5 = CMD_W'(5);
  localparam logic [CMD_W-1:0] CMD_RSVD6 = CMD_W'(6);
  localparam logic [CMD_W-1:0] CMD_RSVD7 = CMD_W'(7);

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  wrc_in_if  in_ch ();
  wrc_out_if out_ch ();

  work_rest_countdown_fsm_top #(
    .TIME_WIDTH(TW)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // countdown model state
  mode_e            cd_mode;
  logic             cd_phase;
  logic             cd_field;
  logic             cd_alarm;
  logic [TW-1:0]    cd_deadline;
  logic [SEC_W-1:0] cd_saved;
  logic [SEC_W-1:0] cd_shown;
  logic [MIN_W-1:0] cd_work;
  logic [MIN_W-1:0] cd_rest;
  logic [MIN_W-1:0] clamp_lo;
  logic [MIN_W-1:0] clamp_hi;

  result_t          frames_due[$];
  logic [NOW_W-1:0] wall_clock;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               err_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [SEC_W-1:0] minutes_to_secs(input logic [MIN_W-1:0] m);
    return SEC_W'(m) * SEC_W'(60);
  endfunction

  function automatic logic [SEC_W-1:0] secs_to_deadline(input logic [TW-1:0] now_t,
                                                        output logic expired);
    logic [TW-1:0] diff;
    diff = cd_deadline - now_t;
    expired = (diff == '0) || diff[TW-1];
    if (expired) begin
      return '0;
    end
    if (diff > TW'(SEC_MAX)) begin
      return SEC_MAX;
    end
    return SEC_W'(diff);
  endfunction

  function automatic logic [MIN_W-1:0] clamp_minutes(input logic [MIN_W-1:0] val,
                                                     input logic signed [STEP_W-1:0] step);
    int lo;
    int hi;
    int sum;
    lo = int'(clamp_lo);
    hi = int'(clamp_hi);
    if (lo < int'(MINUTES_LO)) lo = int'(MINUTES_LO);
    else if (lo > int'(MINUTES_HI)) lo = int'(MINUTES_HI);
    if (hi < int'(MINUTES_LO)) hi = int'(MINUTES_LO);
    else if (hi > int'(MINUTES_HI)) hi = int'(MINUTES_HI);
    sum = int'(val) + int'(step);
    if (sum < lo) sum = lo;
    else if (sum > hi) sum = hi;
    return MIN_W'(sum);
  endfunction

  function automatic result_t advance_countdown(input item_t it);
    logic [TW-1:0]    now_t;
    logic [SEC_W-1:0] left;
    logic [SEC_W-1:0] prev;
    logic             expired;
    logic             dummy;
    logic             redraw;
    result_t          r;
    now_t  = TW'(it.now_seconds);
    redraw = 1'b0;
    left   = secs_to_deadline(now_t, expired);
    case (cd_mode)
      MODE_IDLE: begin
        if (it.cmd == CMD_ACT) begin
          cd_mode     = MODE_RUN;
          cd_deadline = now_t + TW'(minutes_to_secs(cd_phase ? cd_rest : cd_work));
          redraw      = 1'b1;
        end else if (it.cmd == CMD_ACT2) begin
          cd_mode  = MODE_EDIT;
          cd_field = 1'b0;
          redraw   = 1'b1;
        end
      end
      MODE_RUN: begin
        if (it.cmd == CMD_ACT) begin
          cd_mode  = MODE_PAUSE;
          cd_saved = left;
          redraw   = 1'b1;
        end
        if (expired) begin
          cd_mode  = MODE_ALARM;
          cd_alarm = 1'b1;
          redraw   = 1'b1;
        end
        if (it.cmd == CMD_ACT2) begin
          cd_mode  = MODE_EDIT;
          cd_field = 1'b0;
          redraw   = 1'b1;
        end
      end
      MODE_PAUSE: begin
        if (it.cmd == CMD_ACT) begin
          cd_mode     = MODE_RUN;
          cd_deadline = now_t + TW'(cd_saved);
          redraw      = 1'b1;
        end
        if (it.cmd == CMD_ACT2) begin
          cd_mode  = MODE_EDIT;
          cd_field = 1'b0;
          redraw   = 1'b1;
        end
      end
      MODE_ALARM: begin
        if (it.cmd == CMD_ACT) begin
          cd_alarm = 1'b0;
          if (!cd_phase) begin
            cd_phase    = 1'b1;
            cd_saved    = minutes_to_secs(cd_rest);
            cd_mode     = MODE_RUN;
            cd_deadline = now_t + TW'(minutes_to_secs(cd_rest));
          end else begin
            cd_phase = 1'b0;
            cd_saved = minutes_to_secs(cd_work);
            cd_mode  = MODE_IDLE;
          end
          redraw = 1'b1;
        end
      end
      default: begin
        if (it.cmd == CMD_ACT) begin
          cd_field = ~cd_field;
          redraw   = 1'b1;
        end else if (it.cmd == CMD_ACT2) begin
          cd_mode  = MODE_IDLE;
          cd_saved = minutes_to_secs(cd_phase ? cd_rest : cd_work);
          redraw   = 1'b1;
        end else if (it.cmd == CMD_INC || it.cmd == CMD_DEC) begin
          if (!cd_field) cd_work = clamp_minutes(cd_work, it.edit_step);
          else cd_rest = clamp_minutes(cd_rest, it.edit_step);
          redraw = 1'b1;
        end
      end
    endcase
    prev = cd_shown;
    if (cd_mode == MODE_RUN) cd_shown = secs_to_deadline(now_t, dummy);
    else cd_shown = cd_saved;
    if (prev != cd_shown) redraw = 1'b1;
    r.mode            = cd_mode;
    r.phase           = cd_phase;
    r.edit_field      = cd_field;
    r.display_seconds = cd_shown;
    r.work_length     = cd_work;
    r.rest_length     = cd_rest;
    r.redraw          = redraw;
    r.alarm_on        = cd_alarm;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t due;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (frames_due.size() == 0) begin
        $error("result item with no input item pending");
        err_count++;
      end else begin
        due = frames_due.pop_front();
        check_field("mode", due.mode, out_ch.mode);
        check_field("phase", due.phase, out_ch.phase);
        check_field("edit_field", due.edit_field, out_ch.edit_field);
        check_field("display_seconds", due.display_seconds, out_ch.display_seconds);
        check_field("work_length", due.work_length, out_ch.work_length);
        check_field("rest_length", due.rest_length, out_ch.rest_length);
        check_field("redraw", due.redraw, out_ch.redraw);
        check_field("alarm_on", due.alarm_on, out_ch.alarm_on);
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= it.cmd;
    in_ch.now_seconds <= it.now_seconds;
    in_ch.edit_step   <= it.edit_step;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    frames_due.push_back(advance_countdown(it));
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [NOW_W-1:0] now_s,
                          input int step);
    item_t it;
    it.cmd         = cmd;
    it.now_seconds = now_s;
    it.edit_step   = STEP_W'(step);
    send_item(it);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_clamp(input int lo, input int hi);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_MIN_MINUTES;
    cfg_data <= CFG_DATA_W'(lo);
    @(posedge clk);
    clamp_lo = MIN_W'(lo);
    cfg_idx  <= REG_MAX_MINUTES;
    cfg_data <= CFG_DATA_W'(hi);
    @(posedge clk);
    clamp_hi = MIN_W'(hi);
    cfg_we   <= 1'b0;
  endtask

  function automatic item_t next_button_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 34) it.cmd = CMD_NONE;
    else if (pick < 58) it.cmd = CMD_ACT;
    else if (pick < 68) it.cmd = CMD_ACT2;
    else if (pick < 80) it.cmd = CMD_INC;
    else if (pick < 92) it.cmd = CMD_DEC;
    else it.cmd = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    pick = $urandom_range(0, 99);
    if (cd_mode == MODE_RUN && pick < 8) begin
      // land on or right around the deadline
      wall_clock = cd_deadline[NOW_W-1:0] + NOW_W'($urandom_range(0, 4)) - NOW_W'(2);
    end else if (pick < 70) begin
      wall_clock = wall_clock + NOW_W'($urandom_range(0, 20));
    end else if (pick < 90) begin
      wall_clock = wall_clock + NOW_W'($urandom_range(20, 1500));
    end else if (pick < 97) begin
      wall_clock = wall_clock + NOW_W'($urandom_range(1500, 9000));
    end else begin
      wall_clock = NOW_W'($urandom);
    end
    it.now_seconds = wall_clock;
    if ($urandom_range(0, 1) == 0) it.edit_step = STEP_W'($urandom_range(0, 6)) - STEP_W'(3);
    else it.edit_step = STEP_W'($urandom);
    return it;
  endfunction

  task automatic test_directed();
    send_cmd(CMD_NONE, 0, 0);
    send_cmd(CMD_RSVD5, 0, 0);
    send_cmd(CMD_ACT2, 10, 0);
    send_cmd(CMD_INC, 10, 127);
    send_cmd(CMD_DEC, 10, -128);
    send_cmd(CMD_ACT, 10, 0);
    send_cmd(CMD_INC, 10, 3);
    send_cmd(CMD_ACT2, 10, 0);
    send_cmd(CMD_ACT, 1000, 0);
    send_cmd(CMD_RSVD6, 1030, 0);
    send_cmd(CMD_ACT, 1040, 0);
    send_cmd(CMD_ACT, 5000, 0);
    // expiry exactly at the deadline
    send_cmd(CMD_NONE, 5020, 0);
    send_cmd(CMD_ACT, 5100, 0);
    // expiry and edit request in one item
    send_cmd(CMD_ACT2, 6000, 0);
    send_cmd(CMD_ACT2, 6010, 0);
    send_cmd(CMD_ACT, 7000, 0);
    // pause and expiry in one item
    send_cmd(CMD_ACT, 7480, 0);
    send_cmd(CMD_ACT, 7500, 0);
    send_cmd(CMD_ACT, 2147483000, 0);
    // time going backward leaves a huge positive remainder
    send_cmd(CMD_NONE, 5, 0);
    send_cmd(CMD_ACT, 3, 0);
    send_cmd(CMD_ACT, 31'h7FFF_FFFF, 0);
    send_cmd(CMD_NONE, 31'h7FFF_FFFF, 0);
    // wrapped difference with the sign bit set counts as expired
    send_cmd(CMD_RSVD7, 0, -1);
    send_cmd(CMD_ACT, 10, 0);
    wall_clock = 20;
  endtask

  task automatic test_clamp_bounds();
    int lo_set[6] = '{0, 127, 99, 1, 40, 3};
    int hi_set[6] = '{127, 0, 1, 99, 40, 97};
    for (int k = 0; k < 6; k++) begin
      settle();
      set_clamp(lo_set[k], hi_set[k]);
      send_cmd(CMD_ACT2, wall_clock, 0);
      send_cmd(CMD_INC, wall_clock, 127);
      send_cmd(CMD_DEC, wall_clock, -128);
      send_cmd(CMD_INC, wall_clock, 1);
      send_cmd(CMD_ACT, wall_clock, 0);
      send_cmd(CMD_DEC, wall_clock, -1);
      send_cmd(CMD_INC, wall_clock, 127);
      send_cmd(CMD_ACT2, wall_clock, 0);
    end
  endtask

  task automatic test_random(input int count, input int sender_idle, input int receiver_idle);
    int lo;
    int hi;
    settle();
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    if ($urandom_range(0, 3) == 0) begin
      lo = $urandom_range(0, 127);
      hi = $urandom_range(0, 127);
    end else begin
      lo = $urandom_range(1, 20);
      hi = $urandom_range(lo, 99);
    end
    set_clamp(lo, hi);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) settle();
      send_item(next_button_item());
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = '0;
    in_ch.now_seconds = '0;
    in_ch.edit_step   = '0;
    out_ch.ready      = 1'b0;
    cd_mode           = MODE_IDLE;
    cd_phase          = 1'b0;
    cd_field          = 1'b0;
    cd_alarm          = 1'b0;
    cd_deadline       = '0;
    cd_work           = WORK_MIN_RST;
    cd_rest           = REST_MIN_RST;
    cd_saved          = minutes_to_secs(WORK_MIN_RST);
    cd_shown          = minutes_to_secs(WORK_MIN_RST);
    clamp_lo          = MINUTES_LO;
    clamp_hi          = MINUTES_HI;
    wall_clock        = '0;
    send_idle_pct     = 34;
    recv_idle_pct     = 72;
    err_count         = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_clamp_bounds();
    test_random(290, 34, 72);
    test_random(290, 72, 34);
    test_random(290, 0, 0);
    settle();
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
